[sv/i2cw_pkg.sv]
// Package for the write-only I2C master: phase and command codes, the
// sequencer state and the result item. Used by i2cw_step and the top level.
// No dependencies.
package i2cw_pkg;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
	localparam logic [2:0]  LAST_BIT          = 3'd7;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_START = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_SDA = 4'd1,
		PH_START_SCL = 4'd2,
		PH_BIT_LOW   = 4'd3,
		PH_BIT_HIGH  = 4'd4,
		PH_ACK_LOW   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_STOP_LOW  = 4'd7,
		PH_STOP_HIGH = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bit_index;
		logic [7:0]  shift_byte;
		logic [15:0] tick_count;
		logic        scl_drive;
		logic        sda_drive;
	} seq_state_t;

	typedef struct packed {
		logic scl_pull_low;
		logic sda_pull_low;
		logic busy_res;
		logic ack_valid;
		logic ack_received;
	} result_t;

endpackage

[sv/i2cw_step.sv]
// One tick of the I2C write sequencer: next state and result item from the
// current state, the command and the sampled SDA level.
// Depends on i2cw_pkg.
module i2cw_step (
	input  i2cw_pkg::seq_state_t st,
	input  logic [15:0]          half_period,
	input  logic [1:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 sda_in,
	output i2cw_pkg::seq_state_t st_nxt,
	output i2cw_pkg::result_t    res
);

	logic [15:0] hold;
	logic [16:0] next_cnt;
	logic        done;
	logic        ack_v;
	logic        ack_r;

	assign hold     = (half_period == 16'd0) ? 16'd1 : half_period;
	assign next_cnt = {1'b0, st.tick_count} + 17'd1;
	assign done     = next_cnt >= {1'b0, hold};

	always_comb begin
		st_nxt = st;
		ack_v  = 1'b0;
		ack_r  = 1'b0;
		case (st.phase)
			i2cw_pkg::PH_START_SDA, i2cw_pkg::PH_START_SCL, i2cw_pkg::PH_BIT_LOW,
			i2cw_pkg::PH_BIT_HIGH, i2cw_pkg::PH_ACK_LOW, i2cw_pkg::PH_ACK_HIGH,
			i2cw_pkg::PH_STOP_LOW, i2cw_pkg::PH_STOP_HIGH: begin
				st_nxt.tick_count = next_cnt[15:0];
				if (done) begin
					st_nxt.tick_count = 16'd0;
					case (st.phase)
						i2cw_pkg::PH_START_SDA: begin
							st_nxt.phase     = i2cw_pkg::PH_START_SCL;
							st_nxt.scl_drive = 1'b1;
							st_nxt.sda_drive = 1'b1;
						end
						i2cw_pkg::PH_START_SCL: begin
							st_nxt.phase     = i2cw_pkg::PH_IDLE;
							st_nxt.scl_drive = 1'b1;
							st_nxt.sda_drive = 1'b1;
						end
						i2cw_pkg::PH_BIT_LOW: begin
							st_nxt.phase     = i2cw_pkg::PH_BIT_HIGH;
							st_nxt.scl_drive = 1'b0;
						end
						i2cw_pkg::PH_BIT_HIGH: begin
							if (st.bit_index == i2cw_pkg::LAST_BIT) begin
								st_nxt.phase     = i2cw_pkg::PH_ACK_LOW;
								st_nxt.scl_drive = 1'b1;
								st_nxt.sda_drive = 1'b0;
							end else begin
								st_nxt.bit_index  = st.bit_index + 3'd1;
								st_nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
								st_nxt.phase      = i2cw_pkg::PH_BIT_LOW;
								st_nxt.scl_drive  = 1'b1;
								// A zero bit pulls SDA low.
								st_nxt.sda_drive  = ~st.shift_byte[6];
							end
						end
						i2cw_pkg::PH_ACK_LOW: begin
							st_nxt.phase     = i2cw_pkg::PH_ACK_HIGH;
							st_nxt.scl_drive = 1'b0;
							st_nxt.sda_drive = 1'b0;
						end
						i2cw_pkg::PH_ACK_HIGH: begin
							ack_v            = 1'b1;
							ack_r            = ~sda_in;
							st_nxt.phase     = i2cw_pkg::PH_IDLE;
							st_nxt.scl_drive = 1'b1;
							st_nxt.sda_drive = 1'b1;
						end
						i2cw_pkg::PH_STOP_LOW: begin
							st_nxt.phase     = i2cw_pkg::PH_STOP_HIGH;
							st_nxt.scl_drive = 1'b0;
							st_nxt.sda_drive = 1'b1;
						end
						default: begin
							st_nxt.phase     = i2cw_pkg::PH_IDLE;
							st_nxt.scl_drive = 1'b0;
							st_nxt.sda_drive = 1'b0;
						end
					endcase
				end
			end
			default: begin
				// Idle, or a phase code that means nothing, which counts as idle.
				st_nxt.phase = i2cw_pkg::PH_IDLE;
				case (i2cw_pkg::req_t'(req_type))
					i2cw_pkg::REQ_START: begin
						st_nxt.phase      = i2cw_pkg::PH_START_SDA;
						st_nxt.scl_drive  = 1'b0;
						st_nxt.sda_drive  = 1'b1;
						st_nxt.tick_count = 16'd0;
					end
					i2cw_pkg::REQ_WRITE: begin
						st_nxt.phase      = i2cw_pkg::PH_BIT_LOW;
						st_nxt.shift_byte = data_byte;
						st_nxt.bit_index  = 3'd0;
						st_nxt.scl_drive  = 1'b1;
						st_nxt.sda_drive  = ~data_byte[7];
						st_nxt.tick_count = 16'd0;
					end
					i2cw_pkg::REQ_STOP: begin
						st_nxt.phase      = i2cw_pkg::PH_STOP_LOW;
						st_nxt.scl_drive  = 1'b1;
						st_nxt.sda_drive  = 1'b1;
						st_nxt.tick_count = 16'd0;
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	assign res.scl_pull_low = st_nxt.scl_drive;
	assign res.sda_pull_low = st_nxt.sda_drive;
	assign res.busy_res     = st_nxt.phase != i2cw_pkg::PH_IDLE;
	assign res.ack_valid    = ack_v;
	assign res.ack_received = ack_r;

endmodule

[sv/i2c_master_write_engine_top.sv]
// Write-only I2C master sequencer, one item per bus tick.
// The result item of an accepted item is registered in out_q, or in skid_q while the output is stalled.
// Throughput: one item per cycle while req_stall is low; the state register's feedback
// through the step logic is the only loop. A two-entry output buffer keeps input flowing.
// Reset (arst_n low, asynchronous): phase idle, drives released, buffer empty,
// half period back to 5 ticks.
// Depends on i2cw_pkg and i2cw_step.
module i2c_master_write_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic        sda_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl_pull_low,
	output logic        sda_pull_low,
	output logic        busy_res,
	output logic        ack_valid,
	output logic        ack_received
);

	i2cw_pkg::seq_state_t st_q;
	i2cw_pkg::seq_state_t st_nxt;
	i2cw_pkg::result_t    res_new;
	i2cw_pkg::result_t    out_q;
	i2cw_pkg::result_t    skid_q;
	logic [15:0]          half_period_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic                 accept;
	logic                 out_free;

	i2cw_step u_step (
		.st          (st_q),
		.half_period (half_period_q),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.sda_in      (sda_in),
		.st_nxt      (st_nxt),
		.res         (res_new)
	);

	assign req_stall = skid_valid_q;
	assign accept    = req_valid & ~skid_valid_q;
	assign out_free  = ~out_valid_q | ~res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cw_pkg::HALF_PERIOD_RESET;
			st_q          <= '{phase: i2cw_pkg::PH_IDLE, default: '0};
			out_valid_q   <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				half_period_q <= cfg_wdata;
			end
			if (accept) begin
				st_q <= st_nxt;
			end
			if (out_free) begin
				out_valid_q  <= skid_valid_q | accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload of the output buffer; the valid bits above qualify it.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign res_valid    = out_valid_q;
	assign scl_pull_low = out_q.scl_pull_low;
	assign sda_pull_low = out_q.sda_pull_low;
	assign busy_res     = out_q.busy_res;
	assign ack_valid    = out_q.ack_valid;
	assign ack_received = out_q.ack_received;

endmodule

[sv/i2cw_checker.sv]
// Port-level checks for the I2C write master, attached to the top level by bind.
// Depends only on the top level's ports.
module i2cw_checker (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic res_valid,
	input logic res_stall,
	input logic scl_pull_low,
	input logic sda_pull_low,
	input logic busy_res,
	input logic ack_valid,
	input logic ack_received
);

	// An acknowledge result is only reported together with its sample flag.
	a_ack_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ack_received |-> ack_valid)
		else $error("ack_received without ack_valid");

	// The acknowledge sample ends the write: idle with both lines held low.
	a_ack_ends_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ack_valid |-> !busy_res && scl_pull_low && sda_pull_low)
		else $error("acknowledge item does not end the write");

	// Input is held off only while a result item is waiting.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid)
		else $error("input stalled with no result pending");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(scl_pull_low)
		&& $stable(sda_pull_low) && $stable(busy_res) && $stable(ack_valid)
		&& $stable(ack_received))
		else $error("stalled result item changed");

endmodule

bind i2c_master_write_engine_top i2cw_checker u_i2cw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_stall    (req_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.scl_pull_low (scl_pull_low),
	.sda_pull_low (sda_pull_low),
	.busy_res     (busy_res),
	.ack_valid    (ack_valid),
	.ack_received (ack_received)
);
